// ----- sv/ccp_pkg.sv -----
`default_nettype none

package ccp_pkg;

    // characters with a meaning of their own
    localparam logic [7:0] CHAR_EXCL  = 8'h21;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_S  = 8'h53;
    localparam logic [7:0] CHAR_UP_E  = 8'h45;
    localparam logic [7:0] CHAR_UP_T  = 8'h54;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UP_I  = 8'h49;
    localparam logic [7:0] CHAR_UP_M  = 8'h4D;

    // only the head of a line is kept
    localparam int KEPT_CHARS = 21;

    // two-digit fields, first one at FIELD_BASE, then every FIELD_STEP chars
    localparam int NUM_FIELDS = 6;
    localparam int FIELD_BASE = 4;
    localparam int FIELD_STEP = 3;

    localparam int FLD_DATE   = 0;
    localparam int FLD_MONTH  = 1;
    localparam int FLD_YEAR   = 2;
    localparam int FLD_HOUR   = 3;
    localparam int FLD_MINUTE = 4;
    localparam int FLD_SECOND = 5;

    localparam logic [6:0] MAX_DATE    = 7'd31;
    localparam logic [6:0] MAX_MONTH   = 7'd12;
    localparam logic [6:0] MAX_HOUR    = 7'd23;
    localparam logic [6:0] MAX_MIN_SEC = 7'd59;

    typedef enum logic [3:0] {
        ST_SET_OK     = 4'd0,
        ST_FORMAT     = 4'd1,
        ST_BAD_DATE   = 4'd2,
        ST_BAD_MONTH  = 4'd3,
        ST_BAD_HOUR   = 4'd4,
        ST_BAD_MINUTE = 4'd5,
        ST_BAD_SECOND = 4'd6,
        ST_TIME_REQ   = 4'd7,
        ST_UNKNOWN    = 4'd8
    } t_status;

    typedef logic [KEPT_CHARS-1:0][7:0] t_line_chars;

    typedef struct packed {
        t_status    status;
        logic [6:0] bcd_second;
        logic [6:0] bcd_minute;
        logic [5:0] bcd_hour;
        logic [5:0] bcd_date;
        logic [4:0] bcd_month;
        logic [7:0] bcd_year;
    } t_parse;

endpackage

`default_nettype wire

// ----- sv/ccp_line_buf.sv -----
`default_nettype none

module ccp_line_buf #(
    parameter int LINE_CAPACITY = 64,
    parameter int LEN_W         = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [7:0]           i_char,
    output ccp_pkg::t_line_chars      o_chars,
    output logic      [LEN_W-1:0]     o_len,
    output logic                      o_store
);
    import ccp_pkg::*;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [LEN_W-1:0] LEN_KEPT  = LEN_W'(KEPT_CHARS);

    t_line_chars      r_chars;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             is_excl;

    assign is_excl = (i_char == CHAR_EXCL);
    assign o_store = !is_excl && (i_char != CHAR_CR) && (i_char != CHAR_LF)
                     && (r_len < LEN_LIMIT);

    always_comb begin
        n_len = r_len;
        if (i_wr) begin
            if (is_excl) begin
                n_len = '0;
            end else if (o_store) begin
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    // character store: no reset, only written positions are ever looked at
    always_ff @(posedge i_clk) begin
        if (i_wr && o_store && (r_len < LEN_KEPT)) begin
            r_chars[r_len[4:0]] <= i_char;
        end
    end

    assign o_chars = r_chars;
    assign o_len   = r_len;

endmodule

`default_nettype wire

// ----- sv/ccp_classify.sv -----
`default_nettype none

module ccp_classify #(
    parameter int LEN_W = 6
) (
    input  wire ccp_pkg::t_line_chars i_chars,
    input  wire logic [LEN_W-1:0]     i_len,
    output ccp_pkg::t_parse           o_parse
);
    import ccp_pkg::*;

    logic [KEPT_CHARS-1:0] pos_vld;
    logic [KEPT_CHARS-1:0] pos_dig;
    logic [NUM_FIELDS-1:0] fld_ok;
    logic [NUM_FIELDS-1:0][6:0] fld_val;
    logic [NUM_FIELDS-1:0][7:0] fld_bcd;
    logic is_set;
    logic is_time;

    // a position past the line end is never a digit nor a match
    for (genvar i = 0; i < KEPT_CHARS; i++) begin : g_pos
        assign pos_vld[i] = (32'(i_len) > i);
        assign pos_dig[i] = pos_vld[i] && (i_chars[i] >= CHAR_ZERO)
                            && (i_chars[i] <= CHAR_NINE);
    end

    for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_fld
        localparam int P = FIELD_BASE + FIELD_STEP * k;
        logic [3:0] hi;
        logic [3:0] lo;
        assign hi         = i_chars[P][3:0];
        assign lo         = i_chars[P+1][3:0];
        assign fld_ok[k]  = pos_dig[P] && pos_dig[P+1];
        assign fld_bcd[k] = {hi, lo};
        // hi * 10 + lo
        assign fld_val[k] = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    end

    assign is_set = pos_vld[0] && pos_vld[1] && pos_vld[2] && pos_vld[3]
                    && (i_chars[0] == CHAR_UP_S) && (i_chars[1] == CHAR_UP_E)
                    && (i_chars[2] == CHAR_UP_T) && (i_chars[3] == CHAR_SPACE);

    assign is_time = (i_len == LEN_W'(4))
                     && (i_chars[0] == CHAR_UP_T) && (i_chars[1] == CHAR_UP_I)
                     && (i_chars[2] == CHAR_UP_M) && (i_chars[3] == CHAR_UP_E);

    always_comb begin
        o_parse = '0;
        if (is_set) begin
            if (!(&fld_ok)) begin
                o_parse.status = ST_FORMAT;
            end else if (fld_val[FLD_DATE] == 7'd0 || fld_val[FLD_DATE] > MAX_DATE) begin
                o_parse.status = ST_BAD_DATE;
            end else if (fld_val[FLD_MONTH] == 7'd0 || fld_val[FLD_MONTH] > MAX_MONTH) begin
                o_parse.status = ST_BAD_MONTH;
            end else if (fld_val[FLD_HOUR] > MAX_HOUR) begin
                o_parse.status = ST_BAD_HOUR;
            end else if (fld_val[FLD_MINUTE] > MAX_MIN_SEC) begin
                o_parse.status = ST_BAD_MINUTE;
            end else if (fld_val[FLD_SECOND] > MAX_MIN_SEC) begin
                o_parse.status = ST_BAD_SECOND;
            end else begin
                o_parse.status     = ST_SET_OK;
                o_parse.bcd_second = fld_bcd[FLD_SECOND][6:0];
                o_parse.bcd_minute = fld_bcd[FLD_MINUTE][6:0];
                o_parse.bcd_hour   = fld_bcd[FLD_HOUR][5:0];
                o_parse.bcd_date   = fld_bcd[FLD_DATE][5:0];
                o_parse.bcd_month  = fld_bcd[FLD_MONTH][4:0];
                o_parse.bcd_year   = fld_bcd[FLD_YEAR];
            end
        end else if (is_time) begin
            o_parse.status = ST_TIME_REQ;
        end else begin
            o_parse.status = ST_UNKNOWN;
        end
    end

endmodule

`default_nettype wire

// ----- sv/clock_set_command_parser.sv -----
// clock set command parser
// slave channel: one received character per item on s_axis_tdata
// master channel: one result item per input item, every character gives one;
//   tuser flags an echo, tlast marks the item of the '!' that finished a line,
//   tdata holds the echo character, the line status and the six bcd clock fields
// a line collects characters until '!', cr and lf are dropped; "SET " lines are
//   parsed as date, month, year, hour, minute, second, "TIME" is a time request
// path: an item taken is held in the input register, its result goes into the
//   result register and is shown on the master side from there
// throughput: one item per cycle while the master side takes results; the work
//   is one compare pass on the first 21 stored characters between both registers
// stall: when the master side is held off the result stays put, the input
//   register still takes one more item, then s_axis_tready drops
// reset: synchronous active low, empties both registers and the line length;
//   the character store is not cleared, no clearing pass is needed
`default_nettype none

module clock_set_command_parser #(
    parameter int LINE_CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_char[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // echo_char[7:0], status[11:8], bcd_second[18:12], bcd_minute[25:19],
    // bcd_hour[31:26], bcd_date[37:32], bcd_month[42:38], bcd_year[50:43], zero pad
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,   // line_done
    output logic             m_axis_tuser    // echo_valid[0]
);
    import ccp_pkg::*;

    localparam int LEN_W = $clog2(LINE_CAPACITY);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;

    // result register
    logic        r_out_valid;
    logic [55:0] r_out_data;
    logic        r_out_last;
    logic        r_out_user;
    logic [55:0] n_out_data;
    logic        n_out_last;
    logic        n_out_user;

    logic             out_free;
    logic             adv;
    logic             store;
    logic             line_done;
    t_line_chars      chars;
    logic [LEN_W-1:0] len;
    t_parse           parse;
    t_parse           parse_out;
    logic [7:0]       echo_char;

    // result slot frees up when empty or being taken this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
        end
    end

    // line store updates as the item moves into the result register
    ccp_line_buf #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .LEN_W         (LEN_W)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (adv),
        .i_char  (r_in_char),
        .o_chars (chars),
        .o_len   (len),
        .o_store (store)
    );

    // classification sees the line before the terminator clears it
    ccp_classify #(
        .LEN_W (LEN_W)
    ) u_classify (
        .i_chars (chars),
        .i_len   (len),
        .o_parse (parse)
    );

    assign line_done = (r_in_char == CHAR_EXCL);
    assign echo_char = store ? r_in_char : 8'h00;
    assign parse_out = line_done ? parse : '0;

    assign n_out_last = line_done;
    assign n_out_user = store;
    assign n_out_data = {5'b00000,
                         parse_out.bcd_year,
                         parse_out.bcd_month,
                         parse_out.bcd_date,
                         parse_out.bcd_hour,
                         parse_out.bcd_minute,
                         parse_out.bcd_second,
                         parse_out.status,
                         echo_char};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
            r_out_user <= n_out_user;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    // a terminator that moves on leaves an empty line behind
    a_excl_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && line_done) |=> (len == '0))
        else $error("line not cleared after terminator");

    // line length never passes the capacity limit
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(len) <= LINE_CAPACITY - 1))
        else $error("line length beyond capacity");

    // a new result only comes from a held input item
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an input item");

endmodule

`default_nettype wire
